// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cross mean blur checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CNMB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define CNMB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cnmb_pkg.sv
// ----------------------------------------------------------------------------
// cnmb_pkg
// Types, constants and helpers of the cross neighbour mean blur.
// ----------------------------------------------------------------------------
`default_nettype none

package cnmb_pkg;

   localparam int MAX_ROW_BYTES = 8192;
   localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);

   localparam int BYTE_W        = 8;
   localparam int ROW_BYTES_W   = 14;
   localparam int PAD_W         = 2;
   localparam int IMAGE_W       = 26;
   localparam int COL_W         = ((ROW_BYTES_W > ADDR_W) ? ROW_BYTES_W : ADDR_W) + 1;

   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = IMAGE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PADDING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_BYTES = 2'd2;

   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST   = 14'd3;
   localparam logic [PAD_W-1:0]       ROW_PADDING_RST = 2'd0;
   localparam logic [IMAGE_W-1:0]     IMAGE_BYTES_RST = 26'd3;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   // sum of up to five bytes, divided by a count of one to five
   localparam int SUM_W       = 11;
   localparam int CNT_W       = 3;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] pixel_byte;
   } cnmb_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] blurred_byte;
      logic              last;
   } cnmb_rsp_type;

   function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] col,
                                                 input logic [COL_W-1:0] stride);
      logic [COL_W:0] inc;
      inc = {1'b0, col} + 1'b1;
      return (inc >= {1'b0, stride}) ? '0 : inc[COL_W-1:0];
   endfunction

   // 2^16 / cnt, rounded up; exact floor for sums up to five bytes
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         3'd2:    r = 17'd32768;
         3'd3:    r = 17'd21846;
         3'd4:    r = 17'd16384;
         3'd5:    r = 17'd13108;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cross_neighbour_mean_blur.sv
// ----------------------------------------------------------------------------
// cross_neighbour_mean_blur
// Cross-shaped mean filter over a padded 24-bit bitmap byte stream.
// ----------------------------------------------------------------------------
// Image bytes enter on req_* in row-major order, padding included; a flush
// transfer (req_type set) pushes out one byte of the final row once all image
// bytes are in. Results leave on rsp_* one padded row behind the input, with
// last set on the final byte of the image; counters then rewind for the next
// image. Row geometry is set through csr_* between images.
// Throughput: one byte per cycle unless stalled, set by the two line-buffer
// memories (two read ports on the middle row, one on the older row, one write
// each). A byte whose input column differs from the output column (only after
// a geometry change inside an image) holds off the next byte: the middle row
// port is read a second time before the older row is written.
// Reset: synchronous; settings return to their defaults, counters to zero.
// Line buffers are not cleared; no entry is used before it is written.
// When rsp_ready is low the result register holds, the pipeline fills, and
// req_ready drops until space frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_neighbour_mean_blur
   import cnmb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire cnmb_req_type          req_data,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output cnmb_rsp_type               rsp_data,

   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic [PAD_W-1:0]       row_padding_ff, row_padding_in;
   logic [IMAGE_W-1:0]     image_bytes_ff, image_bytes_in;

   // position counters
   logic [IMAGE_W-1:0] in_pos_ff, in_pos_in;
   logic [IMAGE_W-1:0] out_pos_ff, out_pos_in;
   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;

   // line buffers
   logic [BYTE_W-1:0] middle_mem [MAX_ROW_BYTES];
   logic [BYTE_W-1:0] older_mem  [MAX_ROW_BYTES];
   logic [BYTE_W-1:0] mid_a_ff, mid_b_ff, old_a_ff, mid_old_ff;

   // older row write, in the cycle after the transfer
   logic              owr_pend_ff, owr_pend_in;
   logic              owr_mism_ff, owr_mism_in;
   logic [ADDR_W-1:0] owr_addr_ff, owr_addr_in;
   logic              phase_ff, phase_in;
   logic [ADDR_W-1:0] right_addr_ff, right_addr_in;

   // stage 1
   logic              s1_vld_ff, s1_vld_in;
   logic              s1_pad_ff, s1_older_ff, s1_left_ff, s1_right_ff, s1_above_ff;
   logic              s1_sub_ff, s1_last_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_pad_in, s1_older_in, s1_left_in, s1_right_in, s1_above_in;
   logic              s1_sub_in, s1_last_in;
   logic [BYTE_W-1:0] s1_byte_in;

   logic [BYTE_W-1:0] tap0_ff, tap1_ff, tap2_ff;
   logic [BYTE_W-1:0] tap0_in, tap1_in, tap2_in;

   // stage 2
   logic             s2_vld_ff, s2_vld_in;
   logic [SUM_W-1:0] s2_sum_ff, s2_sum_in;
   logic [CNT_W-1:0] s2_cnt_ff, s2_cnt_in;
   logic             s2_last_ff, s2_last_in;

   // result register
   logic         rsp_vld_ff, rsp_vld_in;
   cnmb_rsp_type rsp_data_ff, rsp_data_in;

   // stage 0 decode
   logic [COL_W-1:0]   eff_rb, stride;
   logic [COL_W:0]     out_col_p3;
   logic [IMAGE_W:0]   out_pos_p1, out_pos_p3;
   logic               is_pixel, in_done, out_done, past_first;
   logic               emit_pix, emit_fl, emit, store_pix, owr_now, mismatch;
   logic               is_last, accept;
   logic [ADDR_W-1:0]  rd_b_addr;
   logic               rd_a_en, rd_b_en;

   // flow control
   logic s1_ready, s1_go, s2_free, out_load;

   // stage 1 arithmetic
   logic [BYTE_W-1:0] right_val;
   logic [SUM_W-1:0]  sum;
   logic [CNT_W-1:0]  cnt;
   logic [PROD_W-1:0] prod;

   assign eff_rb = (int'(row_bytes_ff) > MAX_ROW_BYTES) ? COL_W'(MAX_ROW_BYTES)
                                                        : COL_W'(row_bytes_ff);
   assign stride = eff_rb + COL_W'(row_padding_ff);

   assign out_col_p3 = {1'b0, out_col_ff} + (COL_W+1)'(3);
   assign out_pos_p1 = {1'b0, out_pos_ff} + (IMAGE_W+1)'(1);
   assign out_pos_p3 = {1'b0, out_pos_ff} + (IMAGE_W+1)'(3);

   assign is_pixel   = (req_data.req_type == REQ_PIXEL);
   assign in_done    = (in_pos_ff >= image_bytes_ff);
   assign out_done   = (out_pos_ff >= image_bytes_ff);
   assign past_first = (in_pos_ff >= IMAGE_W'(stride));
   assign emit_pix   = is_pixel && !in_done && past_first;
   assign emit_fl    = (req_data.req_type == REQ_FLUSH) && in_done && !out_done;
   assign emit       = emit_pix || emit_fl;
   assign store_pix  = is_pixel && !in_done && (in_col_ff < eff_rb);
   assign owr_now    = emit_pix && (in_col_ff < eff_rb);
   assign mismatch   = owr_now && (in_col_ff != out_col_ff);
   assign is_last    = (out_pos_p1 == {1'b0, image_bytes_ff});

   assign s1_ready  = s1_vld_ff && !phase_ff;
   assign out_load  = !rsp_vld_ff || rsp_ready;
   assign s2_free   = !s2_vld_ff || out_load;
   assign s1_go     = s1_ready && s2_free;
   assign req_ready = !reset && !phase_ff && (!s1_vld_ff || s1_go);
   assign accept    = req_valid && req_ready;

   assign rd_a_en   = accept && emit;
   assign rd_b_en   = rd_a_en || phase_ff;
   assign rd_b_addr = phase_ff ? right_addr_ff
                    : (mismatch ? in_col_ff[ADDR_W-1:0] : out_col_p3[ADDR_W-1:0]);

   // configuration writes
   always_comb begin
      row_bytes_in   = row_bytes_ff;
      row_padding_in = row_padding_ff;
      image_bytes_in = image_bytes_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_BYTES:   row_bytes_in   = csr_wdata[ROW_BYTES_W-1:0];
            CSR_ROW_PADDING: row_padding_in = csr_wdata[PAD_W-1:0];
            CSR_IMAGE_BYTES: image_bytes_in = csr_wdata[IMAGE_W-1:0];
            default: ;
         endcase
      end
   end

   // counters
   always_comb begin
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      in_col_in  = in_col_ff;
      out_col_in = out_col_ff;
      if (accept) begin
         if (is_pixel && !in_done) begin
            in_pos_in = in_pos_ff + 1'b1;
            in_col_in = next_col(in_col_ff, stride);
            if (emit_pix) begin
               out_pos_in = out_pos_p1[IMAGE_W-1:0];
               out_col_in = next_col(out_col_ff, stride);
            end
         end else if (emit_fl) begin
            if (is_last) begin
               in_pos_in  = '0;
               out_pos_in = '0;
               in_col_in  = '0;
               out_col_in = '0;
            end else begin
               out_pos_in = out_pos_p1[IMAGE_W-1:0];
               out_col_in = next_col(out_col_ff, stride);
            end
         end
      end
   end

   // older row write bookkeeping
   always_comb begin
      owr_pend_in   = accept && owr_now;
      owr_mism_in   = mismatch;
      owr_addr_in   = in_col_ff[ADDR_W-1:0];
      phase_in      = accept && mismatch;
      right_addr_in = out_col_p3[ADDR_W-1:0];
   end

   // stage 1 capture
   always_comb begin
      s1_vld_in   = rd_a_en ? 1'b1 : (s1_go ? 1'b0 : s1_vld_ff);
      s1_pad_in   = (out_col_ff >= eff_rb);
      s1_older_in = (out_pos_ff >= IMAGE_W'(stride));
      s1_left_in  = (out_col_ff >= COL_W'(3));
      s1_right_in = (out_col_p3 < {1'b0, eff_rb}) && (out_pos_p3 < {1'b0, image_bytes_ff});
      s1_above_in = is_pixel;
      s1_byte_in  = req_data.pixel_byte;
      s1_last_in  = is_last;
      s1_sub_in   = mismatch && (out_col_p3 == {1'b0, in_col_ff});
   end

   // stage 1 sum and count
   assign right_val = s1_sub_ff ? mid_old_ff : mid_b_ff;

   always_comb begin
      sum = SUM_W'(mid_a_ff)
          + (s1_older_ff ? SUM_W'(old_a_ff)   : '0)
          + (s1_left_ff  ? SUM_W'(tap2_ff)    : '0)
          + (s1_right_ff ? SUM_W'(right_val)  : '0)
          + (s1_above_ff ? SUM_W'(s1_byte_ff) : '0);
      cnt = CNT_W'(1) + CNT_W'(s1_older_ff) + CNT_W'(s1_left_ff)
          + CNT_W'(s1_right_ff) + CNT_W'(s1_above_ff);
      if (s1_pad_ff) begin
         sum = '0;
         cnt = CNT_W'(1);
      end
   end

   always_comb begin
      tap0_in    = tap0_ff;
      tap1_in    = tap1_ff;
      tap2_in    = tap2_ff;
      s2_vld_in  = s1_go ? 1'b1 : (out_load ? 1'b0 : s2_vld_ff);
      s2_sum_in  = s2_sum_ff;
      s2_cnt_in  = s2_cnt_ff;
      s2_last_in = s2_last_ff;
      if (s1_go) begin
         s2_sum_in  = sum;
         s2_cnt_in  = cnt;
         s2_last_in = s1_last_ff;
         if (!s1_pad_ff) begin
            tap2_in = tap1_ff;
            tap1_in = tap0_ff;
            tap0_in = mid_a_ff;
         end
      end
   end

   // stage 2 divide by reciprocal
   assign prod = PROD_W'(s2_sum_ff) * PROD_W'(recip(s2_cnt_ff));

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (out_load) begin
         rsp_vld_in               = s2_vld_ff;
         rsp_data_in.blurred_byte = prod[RECIP_SHIFT +: BYTE_W];
         rsp_data_in.last         = s2_last_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // middle row: write at the transfer, reads before the write
   always_ff @(posedge clock) begin
      if (accept && store_pix) begin
         middle_mem[in_col_ff[ADDR_W-1:0]] <= req_data.pixel_byte;
      end
      if (rd_a_en) begin
         mid_a_ff <= middle_mem[out_col_ff[ADDR_W-1:0]];
      end
      if (rd_b_en) begin
         mid_b_ff <= middle_mem[rd_b_addr];
      end
   end

   // older row: gets the displaced middle byte
   always_ff @(posedge clock) begin
      if (owr_pend_ff) begin
         older_mem[owr_addr_ff] <= owr_mism_ff ? mid_b_ff : mid_a_ff;
      end
      if (rd_a_en) begin
         old_a_ff <= older_mem[out_col_ff[ADDR_W-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (phase_ff) begin
         mid_old_ff <= mid_b_ff;
      end
      if (rd_a_en) begin
         owr_mism_ff   <= owr_mism_in;
         owr_addr_ff   <= owr_addr_in;
         right_addr_ff <= right_addr_in;
         s1_pad_ff     <= s1_pad_in;
         s1_older_ff   <= s1_older_in;
         s1_left_ff    <= s1_left_in;
         s1_right_ff   <= s1_right_in;
         s1_above_ff   <= s1_above_in;
         s1_byte_ff    <= s1_byte_in;
         s1_last_ff    <= s1_last_in;
         s1_sub_ff     <= s1_sub_in;
      end
      s2_sum_ff   <= s2_sum_in;
      s2_cnt_ff   <= s2_cnt_in;
      s2_last_ff  <= s2_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= ROW_BYTES_RST;
         row_padding_ff <= ROW_PADDING_RST;
         image_bytes_ff <= IMAGE_BYTES_RST;
         in_pos_ff      <= '0;
         out_pos_ff     <= '0;
         in_col_ff      <= '0;
         out_col_ff     <= '0;
         owr_pend_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         tap0_ff        <= '0;
         tap1_ff        <= '0;
         tap2_ff        <= '0;
      end else begin
         row_bytes_ff   <= row_bytes_in;
         row_padding_ff <= row_padding_in;
         image_bytes_ff <= image_bytes_in;
         in_pos_ff      <= in_pos_in;
         out_pos_ff     <= out_pos_in;
         in_col_ff      <= in_col_in;
         out_col_ff     <= out_col_in;
         owr_pend_ff    <= owr_pend_in;
         phase_ff       <= phase_in;
         s1_vld_ff      <= s1_vld_in;
         s2_vld_ff      <= s2_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
         tap0_ff        <= tap0_in;
         tap1_ff        <= tap1_in;
         tap2_ff        <= tap2_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cnmb_checker.sv
// ----------------------------------------------------------------------------
// cnmb_checker
// Port-level assertions for the cross neighbour mean blur.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cnmb_checker
   import cnmb_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire cnmb_rsp_type rsp_data
);

   `CNMB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `CNMB_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp changed")
   `CNMB_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `CNMB_ASSERT(a_min_latency, clock, reset, $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3), "result too soon after reset")

endmodule

bind cross_neighbour_mean_blur cnmb_checker u_cnmb_checker (.*);

`default_nettype wire

// File: tb/cross_neighbour_mean_blur_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cross_neighbour_mean_blur_tb
// Self-checking bench for the cross neighbour mean blur.
// ----------------------------------------------------------------------------
// Whole images are streamed through the block, row by row with padding, each
// followed by the flush transfers that push out the final row. A line-buffer
// predictor in the scoreboard works out every blurred byte and its last flag.
// Results are compared in order. Both handshake sides stall at random.
// Geometry changes between images and covers small rows, padding, partial
// last rows, an oversized row and the largest image size.
// ----------------------------------------------------------------------------

class blur_scoreboard;
   logic [cnmb_pkg::ROW_BYTES_W-1:0] row_bytes;
   logic [cnmb_pkg::PAD_W-1:0]       row_padding;
   logic [cnmb_pkg::IMAGE_W-1:0]     image_bytes;
   logic [7:0]                       older_row  [cnmb_pkg::MAX_ROW_BYTES];
   logic [7:0]                       middle_row [cnmb_pkg::MAX_ROW_BYTES];
   logic [7:0]                       taps [3];
   logic [cnmb_pkg::IMAGE_W-1:0]     in_pos;
   logic [cnmb_pkg::IMAGE_W-1:0]     out_pos;
   int unsigned                      in_col;
   int unsigned                      out_col;
   cnmb_pkg::cnmb_rsp_type           expected_q [$];
   int unsigned                      errors;
   int unsigned                      results;

   function new();
      row_bytes   = cnmb_pkg::ROW_BYTES_RST;
      row_padding = cnmb_pkg::ROW_PADDING_RST;
      image_bytes = cnmb_pkg::IMAGE_BYTES_RST;
      foreach (older_row[i]) begin
         older_row[i]  = '0;
         middle_row[i] = '0;
      end
      foreach (taps[i]) taps[i] = '0;
      in_pos  = '0;
      out_pos = '0;
      in_col  = 0;
      out_col = 0;
      errors  = 0;
      results = 0;
   endfunction

   function void write_reg(logic [cnmb_pkg::CSR_IDX_W-1:0] idx,
                           logic [cnmb_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         cnmb_pkg::CSR_ROW_BYTES:   row_bytes   = value[cnmb_pkg::ROW_BYTES_W-1:0];
         cnmb_pkg::CSR_ROW_PADDING: row_padding = value[cnmb_pkg::PAD_W-1:0];
         cnmb_pkg::CSR_IMAGE_BYTES: image_bytes = value[cnmb_pkg::IMAGE_W-1:0];
         default: ;
      endcase
   endfunction

   // oversized rows are clipped to the line buffer depth
   function int unsigned eff_row();
      return (row_bytes > cnmb_pkg::MAX_ROW_BYTES) ? cnmb_pkg::MAX_ROW_BYTES : row_bytes;
   endfunction

   function int unsigned step_col(int unsigned col);
      return (col + 1 >= eff_row() + row_padding) ? 0 : col + 1;
   endfunction

   function logic [7:0] cross_mean(bit above_ok, logic [7:0] above);
      int unsigned rb;
      int unsigned span;
      int unsigned total;
      int unsigned count;
      logic [7:0]  centre;
      rb   = eff_row();
      span = rb + row_padding;
      if (out_col >= rb) return 8'h00;
      centre = middle_row[out_col];
      total  = centre;
      count  = 1;
      if (out_pos >= span) begin
         total += older_row[out_col];
         count++;
      end
      if (out_col >= 3) begin
         total += taps[2];
         count++;
      end
      if (out_col + 3 < rb && out_pos + 3 < image_bytes) begin
         total += middle_row[out_col + 3];
         count++;
      end
      if (above_ok) begin
         total += above;
         count++;
      end
      taps[2] = taps[1];
      taps[1] = taps[0];
      taps[0] = centre;
      return 8'(total / count);
   endfunction

   function bit flush_due();
      return in_pos >= image_bytes && out_pos < image_bytes;
   endfunction

   // returns 0 when the block ignores the transfer
   function bit note_request(cnmb_pkg::cnmb_req_type item);
      int unsigned            rb;
      int unsigned            span;
      cnmb_pkg::cnmb_rsp_type exp_rsp;
      rb   = eff_row();
      span = rb + row_padding;
      if (item.req_type == cnmb_pkg::REQ_PIXEL) begin
         if (in_pos >= image_bytes) return 1'b0;
         if (in_pos >= span) begin
            exp_rsp.blurred_byte = cross_mean(1'b1, item.pixel_byte);
            exp_rsp.last         = (out_pos + 1 == image_bytes);
            expected_q.push_back(exp_rsp);
            out_pos = out_pos + 1'b1;
            out_col = step_col(out_col);
            if (in_col < rb) older_row[in_col] = middle_row[in_col];
         end
         if (in_col < rb) middle_row[in_col] = item.pixel_byte;
         in_pos = in_pos + 1'b1;
         in_col = step_col(in_col);
         return 1'b1;
      end
      if (!flush_due()) return 1'b0;
      exp_rsp.blurred_byte = cross_mean(1'b0, 8'h00);
      exp_rsp.last         = (out_pos + 1 == image_bytes);
      expected_q.push_back(exp_rsp);
      if (exp_rsp.last) begin
         in_pos  = '0;
         out_pos = '0;
         in_col  = 0;
         out_col = 0;
      end else begin
         out_pos = out_pos + 1'b1;
         out_col = step_col(out_col);
      end
      return 1'b1;
   endfunction

   function void check_response(cnmb_pkg::cnmb_rsp_type got);
      cnmb_pkg::cnmb_rsp_type want;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 20)
            $error("unexpected result: blurred_byte %0d last %0d", got.blurred_byte, got.last);
         return;
      end
      want = expected_q.pop_front();
      results++;
      if (got.blurred_byte !== want.blurred_byte) begin
         errors++;
         if (errors <= 20)
            $error("blurred_byte: expected %0d, actual %0d", want.blurred_byte,
                   got.blurred_byte);
      end
      if (got.last !== want.last) begin
         errors++;
         if (errors <= 20)
            $error("last: expected %0d, actual %0d", want.last, got.last);
      end
   endfunction
endclass

module cross_neighbour_mean_blur_tb;
   import cnmb_pkg::*;

   localparam int unsigned MAX_IMAGE = (1 << IMAGE_W) - 1;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   cnmb_req_type          req_data     = '0;
   logic                  rsp_ready    = 1'b0;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;
   logic                  req_ready;
   logic                  rsp_valid;
   cnmb_rsp_type          rsp_data;

   blur_scoreboard sb;
   bit             steady;
   int unsigned    taken_items;
   int unsigned    ignored_items;
   int unsigned    images;

   cross_neighbour_mean_blur u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= 36);
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(logic kind, logic [7:0] value);
      cnmb_req_type item;
      item.req_type   = kind;
      item.pixel_byte = value;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (sb.note_request(item)) taken_items++;
      else ignored_items++;
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // wait out outstanding results and the pipeline tail
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned rb, int unsigned pad, int unsigned img);
      logic [CSR_IDX_W-1:0]  regs  [3] = '{CSR_ROW_BYTES, CSR_ROW_PADDING, CSR_IMAGE_BYTES};
      logic [CSR_DATA_W-1:0] value [3];
      value[0] = CSR_DATA_W'(rb);
      value[1] = CSR_DATA_W'(pad);
      value[2] = CSR_DATA_W'(img);
      for (int i = 0; i < 3; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= regs[i];
         csr_wdata    <= value[i];
         @(posedge clock);
         sb.write_reg(regs[i], value[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic run_image(int unsigned rb, int unsigned pad, int unsigned img, bit noisy);
      drain();
      set_geometry(rb, pad, img);
      for (int unsigned i = 0; i < img; i++) begin
         if (noisy && $urandom_range(99) < 5) send_item(REQ_FLUSH, random_byte());
         send_item(REQ_PIXEL, random_byte());
      end
      if (noisy && $urandom_range(99) < 30) send_item(REQ_PIXEL, random_byte());
      while (sb.flush_due()) send_item(REQ_FLUSH, random_byte());
      if (noisy && $urandom_range(99) < 30) send_item(REQ_FLUSH, random_byte());
      images++;
   endtask

   initial begin
      int unsigned rb;
      int unsigned pad;
      int unsigned span;
      int unsigned img;
      int unsigned goal;
      int unsigned n;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default geometry: early flush, extremes, byte past the end, late flush
      send_item(REQ_FLUSH, 8'hFF);
      send_item(REQ_PIXEL, 8'h00);
      send_item(REQ_PIXEL, 8'hFF);
      send_item(REQ_PIXEL, 8'hFF);
      send_item(REQ_PIXEL, 8'h00);
      while (sb.flush_due()) send_item(REQ_FLUSH, 8'h00);
      send_item(REQ_FLUSH, 8'hFF);
      images++;

      // padded rows, partial last row cutting off right neighbours
      drain();
      set_geometry(6, 1, 11);
      for (int unsigned i = 0; i < 11; i++) begin
         if (i == 5) send_item(REQ_FLUSH, 8'h00);
         send_item(REQ_PIXEL, i[0] ? 8'hFF : 8'h00);
      end
      while (sb.flush_due()) send_item(REQ_FLUSH, 8'hFF);
      images++;

      // widest row, image shorter than one row
      run_image(MAX_ROW_BYTES, 0, 7, 1'b0);

      // largest image size, then cut short to end the image
      drain();
      set_geometry(3, 0, MAX_IMAGE);
      for (int i = 0; i < 30; i++) send_item(REQ_PIXEL, random_byte());
      drain();
      set_geometry(3, 0, 30);
      while (sb.flush_due()) send_item(REQ_FLUSH, random_byte());
      images++;

      goal = taken_items + 760;
      n    = 0;
      while (taken_items < goal) begin
         steady = (n >= 8 && n < 14);
         rb   = ($urandom_range(99) < 80) ? $urandom_range(12, 3) : $urandom_range(40, 13);
         pad  = $urandom_range(3);
         span = rb + pad;
         img  = $urandom_range(5, 1) * span;
         if ($urandom_range(3) == 0) img -= $urandom_range(span - 1, 1);
         if (img < 3) img = 3;
         run_image(rb, pad, img, 1'b1);
         n++;
      end
      steady = 1'b0;

      // oversized row with full padding, image inside the first row
      run_image((1 << ROW_BYTES_W) - 1, 3, 16, 1'b1);

      drain();
      $display("Streamed %0d images (%0d stored or flushed transfers, %0d ignored).",
               images, taken_items, ignored_items);
      $display("Compared %0d blurred bytes against the predictor.", sb.results);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(10_000_000);
      $error("timeout with %0d results outstanding", sb.expected_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: cross_neighbour_mean_blur.f
+incdir+rtl
rtl/cnmb_pkg.sv
rtl/cross_neighbour_mean_blur.sv
rtl/cnmb_checker.sv
tb/cross_neighbour_mean_blur_tb.sv
